### design/itoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared constants, types and helpers of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    // parameter defaults
    localparam int NUMBER_BITS_DEF = 32;
    localparam int MAX_PAD_DEF     = 60;

    // fixed field widths
    localparam int MAG_W   = 32;
    localparam int FIELD_W = 6;
    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 8;

    // longest text of one number
    localparam int MAX_CHARS = 64;

    // quotient bits resolved per divider cycle
    localparam int DIV_STEP_BITS = 4;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_X       = 8'h78;

    // controller states
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIV    = 6'b000010,
        ST_CALC   = 6'b000100,
        ST_LAYOUT = 6'b001000,
        ST_EMIT   = 6'b010000,
        ST_EMPTY  = 6'b100000
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_run;
        logic calc;
        logic layout;
        logic emit_char;
        logic emit_empty;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic radix_ok;
        logic div_finish;
        logic out_free;
        logic at_last;
    } status_t;

    // digit value to its ascii character
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
                                                         input logic upper);
        logic [CHAR_W-1:0] d8;
        logic [CHAR_W-1:0] base;
        d8   = {2'b00, d};
        base = upper ? CH_UPPER_A : CH_LOWER_A;
        if (d < 6'd10) begin
            return CH_ZERO + d8;
        end else begin
            return base + d8 - 8'd10;
        end
    endfunction

endpackage

### design/itoa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_div
// Radix divider: restoring division of the number by the radix, four
// quotient bits per cycle while run is high; each pass leaves the quotient
// in place and yields one digit as the remainder.
// ----------------------------------------------------------------------------
module itoa_div
    import itoa_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  logic [MAG_W-1:0]   magnitude,
    input  logic               run,
    input  logic [RADIX_W-1:0] radix,
    output logic [DIGIT_W-1:0] digit,
    output logic               digit_done,
    output logic               quot_zero
);

    localparam int STEPS  = (NUMBER_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int NW     = STEPS * DIV_STEP_BITS;
    localparam int SW     = $clog2(STEPS);
    localparam int LOAD_W = (NUMBER_BITS < MAG_W) ? NUMBER_BITS : MAG_W;
    localparam logic [SW-1:0] LAST_STEP = SW'(STEPS - 1);

    logic [NW-1:0]            num_reg, num_next;
    logic [DIGIT_W-1:0]       rem_reg, rem_next;
    logic [SW-1:0]            step_reg;
    logic [DIGIT_W-1:0]       r;
    logic [DIGIT_W:0]         trial;
    logic [DIV_STEP_BITS-1:0] top;
    logic [DIV_STEP_BITS-1:0] q;

    // four restoring subtract steps on the top dividend bits
    always_comb begin
        r   = rem_reg;
        top = num_reg[NW-1 -: DIV_STEP_BITS];
        q   = '0;
        for (int i = DIV_STEP_BITS - 1; i >= 0; i--) begin
            trial = {r, top[i]};
            if (trial >= {1'b0, radix}) begin
                q[i]  = 1'b1;
                trial = trial - {1'b0, radix};
            end
            r = trial[DIGIT_W-1:0];
        end
        rem_next = r;
        num_next = {num_reg[NW-DIV_STEP_BITS-1:0], q};
    end

    assign digit_done = run && (step_reg == LAST_STEP);
    assign digit      = rem_next;
    assign quot_zero  = (num_next == '0);

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (load) begin
            step_reg <= '0;
        end else if (run) begin
            step_reg <= (step_reg == LAST_STEP) ? '0 : step_reg + 1'b1;
        end
    end

    // dividend and partial remainder
    always_ff @(posedge aclk) begin
        if (load) begin
            num_reg <= NW'(magnitude[LOAD_W-1:0]);
            rem_reg <= '0;
        end else if (run) begin
            num_reg <= num_next;
            rem_reg <= (step_reg == LAST_STEP) ? '0 : rem_next;
        end
    end

endmodule

### design/itoa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_dp
// Formatter datapath: request registers, radix divider, digit stack,
// field layout and the output register.
// ----------------------------------------------------------------------------
module itoa_dp
    import itoa_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF,
    parameter int MAX_PAD     = MAX_PAD_DEF
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [MAG_W-1:0]   s_magnitude,
    input  logic               s_is_negative,
    input  logic [RADIX_W-1:0] s_radix,
    input  logic [FIELD_W-1:0] s_field_width,
    input  logic [FIELD_W-1:0] s_min_digits,
    input  logic               s_flag_left,
    input  logic               s_flag_zero_pad,
    input  logic               s_flag_signed,
    input  logic               s_flag_plus,
    input  logic               s_flag_space,
    input  logic               s_flag_prefix,
    input  logic               s_flag_upper,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [CHAR_W-1:0]  m_character,
    output logic               m_last,
    output logic               m_empty_res
);

    localparam int ND_W = $clog2(NUMBER_BITS + 1);
    localparam logic [FIELD_W-1:0] PAD_LIMIT = FIELD_W'(MAX_PAD);

    // request registers
    logic               upper_reg, left_reg, zero_reg;
    logic [RADIX_W-1:0] radix_reg;
    logic [CHAR_W-1:0]  sign_ch_reg;
    logic [1:0]         pref_n_reg;
    logic [POS_W-1:0]   wadj_reg;
    logic [FIELD_W-1:0] prec_sat_reg;

    // load-time decode
    logic [CHAR_W-1:0]  sign_ch_next;
    logic               sign_n_next;
    logic               oct_pref;
    logic [1:0]         pref_n_next;
    logic [FIELD_W-1:0] width_sat;
    logic [FIELD_W-1:0] prec_sat;

    always_comb begin
        sign_ch_next = CH_NUL;
        if (s_flag_signed) begin
            if (s_is_negative) begin
                sign_ch_next = CH_MINUS;
            end else if (s_flag_plus) begin
                sign_ch_next = CH_PLUS;
            end else if (s_flag_space) begin
                sign_ch_next = CH_SPACE;
            end
        end
        sign_n_next = (sign_ch_next != CH_NUL);
        oct_pref    = s_flag_prefix && (s_radix == RADIX_OCT);
        if (oct_pref) begin
            pref_n_next = 2'd1;
        end else if (s_flag_prefix && (s_radix == RADIX_HEX)) begin
            pref_n_next = 2'd2;
        end else begin
            pref_n_next = 2'd0;
        end
        width_sat = (s_field_width > PAD_LIMIT) ? PAD_LIMIT : s_field_width;
        prec_sat  = (s_min_digits > PAD_LIMIT) ? PAD_LIMIT : s_min_digits;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            upper_reg    <= s_flag_upper;
            left_reg     <= s_flag_left;
            zero_reg     <= s_flag_zero_pad && !s_flag_left;
            radix_reg    <= s_radix;
            sign_ch_reg  <= sign_ch_next;
            pref_n_reg   <= pref_n_next;
            // width left after sign and octal prefix, may go negative
            wadj_reg     <= POS_W'(width_sat) - POS_W'(sign_n_next) - POS_W'(oct_pref);
            prec_sat_reg <= prec_sat;
        end
    end

    assign status.radix_ok = (s_radix >= RADIX_MIN) && (s_radix <= RADIX_MAX);

    // radix divider
    logic [DIGIT_W-1:0] digit;
    logic               digit_done;
    logic               quot_zero;

    itoa_div #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (cmd.load),
        .magnitude  (s_magnitude),
        .run        (cmd.div_run),
        .radix      (radix_reg),
        .digit      (digit),
        .digit_done (digit_done),
        .quot_zero  (quot_zero)
    );

    assign status.div_finish = cmd.div_run && digit_done && quot_zero;

    // digit stack, least significant digit pushed first, top at entry 0
    logic [DIGIT_W-1:0] stack_reg [NUMBER_BITS];
    logic [ND_W-1:0]    nd_reg;
    logic               push, pop;
    logic               digit_seg;

    assign push = cmd.div_run && digit_done;
    assign pop  = cmd.emit_char && digit_seg;

    always_ff @(posedge aclk) begin
        if (push) begin
            stack_reg[0] <= digit;
            for (int i = 1; i < NUMBER_BITS; i++) begin
                stack_reg[i] <= stack_reg[i-1];
            end
        end else if (pop) begin
            for (int i = 0; i < NUMBER_BITS - 1; i++) begin
                stack_reg[i] <= stack_reg[i+1];
            end
            stack_reg[NUMBER_BITS-1] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nd_reg <= '0;
        end else if (cmd.load) begin
            nd_reg <= '0;
        end else if (push) begin
            nd_reg <= nd_reg + 1'b1;
        end else if (pop) begin
            nd_reg <= nd_reg - 1'b1;
        end
    end

    // padding counts
    logic [POS_W-1:0] lead_reg, zpad_reg, trail_reg, precz_reg;
    logic [POS_W-1:0] prec, pad, padp;

    always_comb begin
        prec = (POS_W'(prec_sat_reg) > POS_W'(nd_reg)) ? POS_W'(prec_sat_reg)
                                                      : POS_W'(nd_reg);
        pad  = wadj_reg - prec;
        padp = pad[POS_W-1] ? '0 : pad;
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            lead_reg  <= (!left_reg && !zero_reg) ? padp : '0;
            zpad_reg  <= zero_reg ? padp : '0;
            trail_reg <= left_reg ? padp : '0;
            precz_reg <= prec - POS_W'(nd_reg);
        end
    end

    // segment end positions
    logic [POS_W-1:0] end_lead_reg, end_sign_reg, end_pref_reg, end_zero_reg;
    logic [POS_W-1:0] end_dig_reg, last_pos_reg;
    logic [POS_W-1:0] e_sign, e_pref, e_zero, e_dig, e_tot, e_lim;

    always_comb begin
        e_sign = lead_reg + POS_W'(sign_ch_reg != CH_NUL);
        e_pref = e_sign + POS_W'(pref_n_reg);
        e_zero = e_pref + zpad_reg + precz_reg;
        e_dig  = e_zero + POS_W'(nd_reg);
        e_tot  = e_dig + trail_reg;
        e_lim  = (e_tot > POS_W'(MAX_CHARS)) ? POS_W'(MAX_CHARS) : e_tot;
    end

    always_ff @(posedge aclk) begin
        if (cmd.layout) begin
            end_lead_reg <= lead_reg;
            end_sign_reg <= e_sign;
            end_pref_reg <= e_pref;
            end_zero_reg <= e_zero;
            end_dig_reg  <= e_dig;
            last_pos_reg <= e_lim - 1'b1;
        end
    end

    // character position
    logic [POS_W-1:0] pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (cmd.layout) begin
            pos_reg <= '0;
        end else if (cmd.emit_char) begin
            pos_reg <= pos_reg + 1'b1;
        end
    end

    // character select
    logic [CHAR_W-1:0] ch;

    always_comb begin
        digit_seg = (pos_reg >= end_zero_reg) && (pos_reg < end_dig_reg);
        if (pos_reg < end_lead_reg) begin
            ch = CH_SPACE;
        end else if (pos_reg < end_sign_reg) begin
            ch = sign_ch_reg;
        end else if (pos_reg < end_pref_reg) begin
            ch = (pos_reg == end_sign_reg) ? CH_ZERO : CH_X;
        end else if (pos_reg < end_zero_reg) begin
            ch = CH_ZERO;
        end else if (digit_seg) begin
            ch = digit_to_ascii(stack_reg[0], upper_reg);
        end else begin
            ch = CH_SPACE;
        end
    end

    assign status.at_last = (pos_reg == last_pos_reg);

    // output register
    logic              m_valid_reg;
    logic [CHAR_W-1:0] m_character_reg;
    logic              m_last_reg;
    logic              m_empty_res_reg;

    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_char || cmd.emit_empty) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_char) begin
            m_character_reg <= ch;
            m_last_reg      <= status.at_last;
            m_empty_res_reg <= 1'b0;
        end else if (cmd.emit_empty) begin
            m_character_reg <= CH_NUL;
            m_last_reg      <= 1'b1;
            m_empty_res_reg <= 1'b1;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;
    assign m_empty_res = m_empty_res_reg;

    // checks
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (nd_reg != '0))
        else $error("digit stack popped while empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (nd_reg < ND_W'(NUMBER_BITS)))
        else $error("digit stack overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.emit_empty) |-> (m_valid && m_last && m_empty_res && (m_character == CH_NUL)))
        else $error("empty result not marked as single last result");

endmodule

### design/itoa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_ctrl
// Formatter controller: sequences accept, digit extraction, layout and
// character emission, or one empty result for a bad radix, one request at a time.
// ----------------------------------------------------------------------------
module itoa_ctrl
    import itoa_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = status.radix_ok ? ST_DIV : ST_EMPTY;
                end
            end
            ST_DIV: begin
                cmd.div_run = 1'b1;
                if (status.div_finish) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_LAYOUT;
            end
            ST_LAYOUT: begin
                cmd.layout = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_char = 1'b1;
                    if (status.at_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMPTY: begin
                if (status.out_free) begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // checks
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !status.radix_ok) |=> (state_reg == ST_EMPTY))
        else $error("invalid radix request did not go to empty result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_char && status.at_last) |=> s_ready)
        else $error("not ready after last character");

endmodule

### design/integer_to_ascii_formatter.sv
// Sequence: an accept state loads the request, the radix divider runs until the quotient
//   is zero, a calc and a layout state follow, then each character is emitted when the
//   output register is free. Throughput: one request at a time, bounded by the divider
//   and the single output register.
// A new request is taken once the last character sits in the output register.
// Reset: synchronous active-low aresetn returns the controller to idle and drops m_valid.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Printf-style integer conversion in radix 2 to 36, one ASCII character
// per result with the final one marked; any other radix gives one empty result.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
    import itoa_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF,
    parameter int MAX_PAD     = MAX_PAD_DEF
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [MAG_W-1:0]   s_magnitude,
    input  logic               s_is_negative,
    input  logic [RADIX_W-1:0] s_radix,
    input  logic [FIELD_W-1:0] s_field_width,
    input  logic [FIELD_W-1:0] s_min_digits,
    input  logic               s_flag_left,
    input  logic               s_flag_zero_pad,
    input  logic               s_flag_signed,
    input  logic               s_flag_plus,
    input  logic               s_flag_space,
    input  logic               s_flag_prefix,
    input  logic               s_flag_upper,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CHAR_W-1:0]  m_character,
    output logic               m_last,
    output logic               m_empty_res
);

    cmd_t    cmd;
    status_t status;

    // controller
    itoa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath
    itoa_dp #(
        .NUMBER_BITS (NUMBER_BITS),
        .MAX_PAD     (MAX_PAD)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_magnitude     (s_magnitude),
        .s_is_negative   (s_is_negative),
        .s_radix         (s_radix),
        .s_field_width   (s_field_width),
        .s_min_digits    (s_min_digits),
        .s_flag_left     (s_flag_left),
        .s_flag_zero_pad (s_flag_zero_pad),
        .s_flag_signed   (s_flag_signed),
        .s_flag_plus     (s_flag_plus),
        .s_flag_space    (s_flag_space),
        .s_flag_prefix   (s_flag_prefix),
        .s_flag_upper    (s_flag_upper),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_character     (m_character),
        .m_last          (m_last),
        .m_empty_res     (m_empty_res)
    );

endmodule

### tb/integer_to_ascii_formatter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_tb
// Self-checking bench for the printf-style integer formatter. Each request is
// turned into its expected character string by a local formatter written in
// SystemVerilog, and every character leaving the block is compared in order.
// Directed cases cover the extremes, signs, prefixes, padding and bad radix;
// a back-pressure case and a random run, later with idle gaps on both sides, follow.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_tb
    import itoa_pkg::*;
();

    localparam int HALF_PERIOD  = 6;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_CYCLES  = 800;
    localparam int REPORT_MAX   = 10;
    localparam int PAD_LIMIT    = MAX_PAD_DEF;

    localparam logic [RADIX_W-1:0] RADIX_BIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_TOP = 6'd63;

    // printf flag masks for building requests
    localparam logic [6:0] FL_NONE   = 7'h00;
    localparam logic [6:0] FL_LEFT   = 7'h01;
    localparam logic [6:0] FL_ZERO   = 7'h02;
    localparam logic [6:0] FL_SIGNED = 7'h04;
    localparam logic [6:0] FL_PLUS   = 7'h08;
    localparam logic [6:0] FL_SPACE  = 7'h10;
    localparam logic [6:0] FL_PREFIX = 7'h20;
    localparam logic [6:0] FL_UPPER  = 7'h40;

    typedef struct {
        logic [MAG_W-1:0]   magnitude;
        logic               is_negative;
        logic [RADIX_W-1:0] radix;
        logic [FIELD_W-1:0] field_width;
        logic [FIELD_W-1:0] min_digits;
        logic               flag_left;
        logic               flag_zero_pad;
        logic               flag_signed;
        logic               flag_plus;
        logic               flag_space;
        logic               flag_prefix;
        logic               flag_upper;
    } format_request_t;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              empty;
    } text_char_t;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [MAG_W-1:0]   s_magnitude = '0;
    logic               s_is_negative = 1'b0;
    logic [RADIX_W-1:0] s_radix = '0;
    logic [FIELD_W-1:0] s_field_width = '0;
    logic [FIELD_W-1:0] s_min_digits = '0;
    logic               s_flag_left = 1'b0;
    logic               s_flag_zero_pad = 1'b0;
    logic               s_flag_signed = 1'b0;
    logic               s_flag_plus = 1'b0;
    logic               s_flag_space = 1'b0;
    logic               s_flag_prefix = 1'b0;
    logic               s_flag_upper = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [CHAR_W-1:0]  m_character;
    logic               m_last;
    logic               m_empty_res;

    text_char_t expected_text[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    logic       gaps_on = 1'b0;
    logic       hold_toggle = 1'b0;
    logic       hold_seen = 1'b0;
    int         hold_left = 0;
    int         stall_left = 0;

    integer_to_ascii_formatter u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_magnitude     (s_magnitude),
        .s_is_negative   (s_is_negative),
        .s_radix         (s_radix),
        .s_field_width   (s_field_width),
        .s_min_digits    (s_min_digits),
        .s_flag_left     (s_flag_left),
        .s_flag_zero_pad (s_flag_zero_pad),
        .s_flag_signed   (s_flag_signed),
        .s_flag_plus     (s_flag_plus),
        .s_flag_space    (s_flag_space),
        .s_flag_prefix   (s_flag_prefix),
        .s_flag_upper    (s_flag_upper),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_character     (m_character),
        .m_last          (m_last),
        .m_empty_res     (m_empty_res)
    );

    // clock
    always begin
        aclk = 1'b0;
        #HALF_PERIOD;
        aclk = 1'b1;
        #HALF_PERIOD;
    end

    // formats one request into the characters the block should emit
    function automatic void format_text(input format_request_t r);
        logic [CHAR_W-1:0] text[$];
        logic [CHAR_W-1:0] rev_digits[$];
        logic [MAG_W-1:0]  num;
        logic [MAG_W-1:0]  dv;
        logic [CHAR_W-1:0] sign_ch;
        logic [CHAR_W-1:0] letter_base;
        logic              zero_fill;
        int                width;
        int                prec;
        int                pad;
        int                idx;
        int                count;
        text_char_t        c;
        if (r.radix < RADIX_MIN || r.radix > RADIX_MAX) begin
            c.ch    = CH_NUL;
            c.last  = 1'b1;
            c.empty = 1'b1;
            expected_text.push_back(c);
            return;
        end
        width       = (int'(r.field_width) > PAD_LIMIT) ? PAD_LIMIT : int'(r.field_width);
        prec        = (int'(r.min_digits) > PAD_LIMIT) ? PAD_LIMIT : int'(r.min_digits);
        zero_fill   = r.flag_zero_pad && !r.flag_left;
        letter_base = r.flag_upper ? CH_UPPER_A : CH_LOWER_A;

        // sign selection, each sign eats one place of width
        sign_ch = CH_NUL;
        if (r.flag_signed) begin
            if (r.is_negative) sign_ch = CH_MINUS;
            else if (r.flag_plus) sign_ch = CH_PLUS;
            else if (r.flag_space) sign_ch = CH_SPACE;
        end
        if (sign_ch != CH_NUL) width--;
        if (r.flag_prefix && r.radix == RADIX_OCT) width--;

        // digits, least significant first; zero gives a single '0'
        num = r.magnitude;
        do begin
            dv  = num % r.radix;
            num = num / r.radix;
            if (dv < 10) rev_digits.push_back(CH_ZERO + dv[CHAR_W-1:0]);
            else rev_digits.push_back(letter_base + dv[CHAR_W-1:0] - 8'd10);
        end while (num != 0);
        if (rev_digits.size() > prec) prec = rev_digits.size();
        pad = width - prec;

        // assemble the field
        if (!r.flag_left && !zero_fill)
            for (idx = 0; idx < pad; idx++) text.push_back(CH_SPACE);
        if (sign_ch != CH_NUL) text.push_back(sign_ch);
        if (r.flag_prefix && r.radix == RADIX_OCT) text.push_back(CH_ZERO);
        if (r.flag_prefix && r.radix == RADIX_HEX) begin
            text.push_back(CH_ZERO);
            text.push_back(CH_X);
        end
        if (zero_fill)
            for (idx = 0; idx < pad; idx++) text.push_back(CH_ZERO);
        for (idx = rev_digits.size(); idx < prec; idx++) text.push_back(CH_ZERO);
        for (idx = rev_digits.size() - 1; idx >= 0; idx--) text.push_back(rev_digits[idx]);
        if (r.flag_left)
            for (idx = 0; idx < pad; idx++) text.push_back(CH_SPACE);

        // overlong text is cut, the final kept character marked last
        count = (text.size() > MAX_CHARS) ? MAX_CHARS : text.size();
        for (idx = 0; idx < count; idx++) begin
            c.ch    = text[idx];
            c.last  = (idx == count - 1);
            c.empty = 1'b0;
            expected_text.push_back(c);
        end
    endfunction

    function automatic format_request_t make_request(input logic [MAG_W-1:0] mag,
                                                     input logic neg,
                                                     input logic [RADIX_W-1:0] radix,
                                                     input logic [FIELD_W-1:0] width,
                                                     input logic [FIELD_W-1:0] prec,
                                                     input logic [6:0] flags);
        format_request_t r;
        r.magnitude     = mag;
        r.is_negative   = neg;
        r.radix         = radix;
        r.field_width   = width;
        r.min_digits    = prec;
        r.flag_left     = |(flags & FL_LEFT);
        r.flag_zero_pad = |(flags & FL_ZERO);
        r.flag_signed   = |(flags & FL_SIGNED);
        r.flag_plus     = |(flags & FL_PLUS);
        r.flag_space    = |(flags & FL_SPACE);
        r.flag_prefix   = |(flags & FL_PREFIX);
        r.flag_upper    = |(flags & FL_UPPER);
        return r;
    endfunction

    // offers one request, optionally after an idle gap, and records its text once taken
    task automatic send_request(input format_request_t r);
        int gap;
        gap = 0;
        if (gaps_on) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: gap = 0;
                6, 7, 8:          gap = $urandom_range(1, 3);
                default:          gap = $urandom_range(8, 30);
            endcase
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_magnitude     <= r.magnitude;
        s_is_negative   <= r.is_negative;
        s_radix         <= r.radix;
        s_field_width   <= r.field_width;
        s_min_digits    <= r.min_digits;
        s_flag_left     <= r.flag_left;
        s_flag_zero_pad <= r.flag_zero_pad;
        s_flag_signed   <= r.flag_signed;
        s_flag_plus     <= r.flag_plus;
        s_flag_space    <= r.flag_space;
        s_flag_prefix   <= r.flag_prefix;
        s_flag_upper    <= r.flag_upper;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        format_text(r);
    endtask

    // drops valid and waits until every pending character has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_text.size() != 0) @(posedge aclk);
    endtask

    // radix outside 2 to 36 gives one empty result
    task automatic test_invalid_radix();
        send_request(make_request(32'd1234, 1'b1, RADIX_MIN - 6'd1, 6'd10, 6'd4,
                                  FL_SIGNED | FL_PREFIX));
        send_request(make_request(32'hdead_beef, 1'b0, 6'd0, 6'd0, 6'd0, FL_NONE));
        send_request(make_request(32'd7, 1'b0, RADIX_MAX + 6'd1, 6'd5, 6'd0, FL_ZERO));
        send_request(make_request(32'hffff_ffff, 1'b1, RADIX_TOP, 6'd63, 6'd63, 7'h7f));
        wait_drained();
    endtask

    // magnitude and radix extremes, width and precision saturation
    task automatic test_extremes();
        send_request(make_request(32'd0, 1'b0, RADIX_DEC, 6'd0, 6'd0, FL_NONE));
        send_request(make_request(32'd0, 1'b1, RADIX_BIN, 6'd0, 6'd0, FL_NONE));
        send_request(make_request(32'hffff_ffff, 1'b0, RADIX_BIN, 6'd0, 6'd0, FL_NONE));
        send_request(make_request(32'hffff_ffff, 1'b0, RADIX_MAX, 6'd0, 6'd0, FL_UPPER));
        send_request(make_request(32'hffff_ffff, 1'b0, RADIX_MAX, 6'd63, 6'd63, FL_NONE));
        send_request(make_request(32'd123456, 1'b0, RADIX_DEC, 6'd60, 6'd0, FL_LEFT));
        wait_drained();
    endtask

    // sign character choices
    task automatic test_sign();
        send_request(make_request(32'd42, 1'b1, RADIX_DEC, 6'd0, 6'd0, FL_SIGNED));
        send_request(make_request(32'd42, 1'b0, RADIX_DEC, 6'd0, 6'd0, FL_SIGNED | FL_PLUS));
        send_request(make_request(32'd42, 1'b0, RADIX_DEC, 6'd6, 6'd0, FL_SIGNED | FL_SPACE));
        send_request(make_request(32'd42, 1'b0, RADIX_DEC, 6'd0, 6'd0,
                                  FL_SIGNED | FL_PLUS | FL_SPACE));
        send_request(make_request(32'd42, 1'b1, RADIX_DEC, 6'd5, 6'd0, FL_PLUS | FL_SPACE));
        wait_drained();
    endtask

    // octal and hex prefix, with and without padding
    task automatic test_prefix();
        send_request(make_request(32'o777, 1'b1, RADIX_OCT, 6'd8, 6'd0,
                                  FL_PREFIX | FL_ZERO | FL_SIGNED));
        send_request(make_request(32'hbeef, 1'b0, RADIX_HEX, 6'd10, 6'd0,
                                  FL_PREFIX | FL_ZERO | FL_UPPER));
        send_request(make_request(32'hcafe, 1'b0, RADIX_HEX, 6'd12, 6'd0, FL_PREFIX | FL_LEFT));
        send_request(make_request(32'd99, 1'b0, RADIX_DEC, 6'd6, 6'd0, FL_PREFIX));
        send_request(make_request(32'o17, 1'b0, RADIX_OCT, 6'd0, 6'd5, FL_PREFIX));
        wait_drained();
    endtask

    // zero pad against left justify, narrow fields, longest text
    task automatic test_padding();
        send_request(make_request(32'd77, 1'b0, RADIX_DEC, 6'd10, 6'd0,
                                  FL_LEFT | FL_ZERO | FL_SIGNED | FL_PLUS));
        send_request(make_request(32'd1234567, 1'b0, RADIX_DEC, 6'd3, 6'd2, FL_ZERO));
        send_request(make_request(32'hffff_ffff, 1'b1, RADIX_HEX, 6'd0, 6'd60,
                                  FL_PREFIX | FL_SIGNED));
        send_request(make_request(32'd5, 1'b1, RADIX_OCT, 6'd61, 6'd62,
                                  FL_PREFIX | FL_SIGNED | FL_ZERO));
        wait_drained();
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_back_pressure();
        int n;
        hold_toggle <= ~hold_toggle;
        for (n = 0; n < 5; n++)
            send_request(make_request($urandom, n[0], RADIX_DEC + n[5:0], 6'd12, 6'd3,
                                      FL_SIGNED | FL_PREFIX));
        wait_drained();
    endtask

    // random requests, first without idling then with gaps on both sides
    task automatic test_random(input int count);
        format_request_t r;
        int              n;
        for (n = 0; n < count; n++) begin
            if (n == 40) gaps_on <= 1'b1;
            case ($urandom_range(0, 3))
                0:       r.magnitude = $urandom;
                1:       r.magnitude = $urandom_range(0, 99);
                2:       r.magnitude = $urandom >> $urandom_range(0, 31);
                default: r.magnitude = $urandom_range(0, 1) ? 32'hffff_ffff - $urandom_range(0, 15)
                                                            : 32'h8000_0000 ^ $urandom_range(0, 15);
            endcase
            case ($urandom_range(0, 19))
                0, 1:       r.radix = $urandom_range(0, 1) ? RADIX_W'($urandom_range(0, 1))
                                                           : RADIX_W'($urandom_range(37, 63));
                2:          r.radix = RADIX_BIN;
                3, 4:       r.radix = RADIX_OCT;
                5, 6:       r.radix = RADIX_DEC;
                7, 8:       r.radix = RADIX_HEX;
                9:          r.radix = RADIX_MAX;
                default:    r.radix = RADIX_W'($urandom_range(2, 36));
            endcase
            r.field_width   = ($urandom_range(0, 4) == 0) ? FIELD_W'($urandom_range(0, 63))
                                                          : FIELD_W'($urandom_range(0, 16));
            r.min_digits    = ($urandom_range(0, 5) == 0) ? FIELD_W'($urandom_range(0, 63))
                                                          : FIELD_W'($urandom_range(0, 10));
            r.is_negative   = 1'($urandom_range(0, 1));
            r.flag_left     = 1'($urandom_range(0, 1));
            r.flag_zero_pad = 1'($urandom_range(0, 1));
            r.flag_signed   = 1'($urandom_range(0, 1));
            r.flag_plus     = 1'($urandom_range(0, 1));
            r.flag_space    = 1'($urandom_range(0, 1));
            r.flag_prefix   = 1'($urandom_range(0, 1));
            r.flag_upper    = 1'($urandom_range(0, 1));
            send_request(r);
        end
        wait_drained();
    endtask

    // receiver ready, with long hold on request and random stalls when idling is on
    always @(posedge aclk) begin
        if (hold_seen != hold_toggle) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 99) < 25) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(0, 2);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic note_mismatch(input string what, input text_char_t want);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch (%s): expected char %h last %b empty %b, got char %h last %b empty %b",
                     what, want.ch, want.last, want.empty, m_character, m_last, m_empty_res);
    endtask

    // compare every delivered character with the oldest pending one
    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_text.size() == 0) begin
                want = '{CH_NUL, 1'b0, 1'b0};
                note_mismatch("nothing pending", want);
            end else begin
                want = expected_text.pop_front();
                if (m_character !== want.ch || m_last !== want.last || m_empty_res !== want.empty)
                    note_mismatch("wrong field", want);
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("integer_to_ascii_formatter regression: fail");
        $finish;
    end

    // test sequence
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_invalid_radix();
        test_extremes();
        test_sign();
        test_prefix();
        test_padding();
        test_back_pressure();
        test_random(240);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_text.size() == 0) begin
            $display("integer_to_ascii_formatter regression: pass");
        end else begin
            $display("integer_to_ascii_formatter regression: fail");
        end
        $finish;
    end

endmodule

### integer_to_ascii_formatter.f
design/itoa_pkg.sv
design/itoa_div.sv
design/itoa_dp.sv
design/itoa_ctrl.sv
design/integer_to_ascii_formatter.sv
tb/integer_to_ascii_formatter_tb.sv
